// File: rtl/core/gcrw_pkg.sv
// Shared types and codes for the graph cover random walk engine.
// Depends on nothing; the top-level engine file refers to it by scoped names.
package gcrw_pkg;

  localparam int NODE_W  = 10;
  localparam int RAND_W  = 16;
  localparam int CNT_W   = 32;
  localparam int COVER_W = 10;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 3;
  localparam int CFG_W   = 11;

  localparam logic [COVER_W-1:0] COVER_MAX = '1;
  localparam logic [CFG_W-1:0]   NODE_COUNT_RST = 11'd1024;

  localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
  localparam logic [OP_W-1:0] OP_START = 3'd2;
  localparam logic [OP_W-1:0] OP_STEP  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NO_NBR  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NO_WALK = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [RAND_W-1:0] rand_first;
    logic [RAND_W-1:0] rand_second;
  } req_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [CNT_W-1:0]   visit_count;
    logic [COVER_W-1:0] covered;
    logic [CNT_W-1:0]   steps;
    logic               done_res;
    logic [STAT_W-1:0]  status;
  } rsp_t;

endpackage

// File: rtl/core/gcrw_mod.sv
// Two-lane remainder unit: r1 mod divisor and r2 mod divisor, four bits a cycle.
// Standalone; instantiated by graph_cover_random_walk.
module gcrw_mod #(
  parameter int RW = 16,
  parameter int DW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [RW-1:0] r1,
  input  logic [RW-1:0] r2,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] rem1,
  output logic [DW-1:0] rem2
);

  localparam int ITER = (RW + 3) / 4;
  localparam int PW   = ITER * 4;
  localparam int CW   = $clog2(ITER + 1);

  logic [PW-1:0] sh1;
  logic [PW-1:0] sh2;
  logic [DW-1:0] dv;
  logic [CW-1:0] cnt;
  logic          busy;

  // shift four numerator bits into the partial remainder, restoring each time
  function automatic logic [DW-1:0] step4(input logic [DW-1:0] r, input logic [3:0] bits,
                                          input logic [DW-1:0] d);
    logic [DW:0] t;
    int          i;
    t = {1'b0, r};
    for (i = 3; i >= 0; i--) begin
      t = {t[DW-1:0], bits[i]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
    end
    return t[DW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(ITER);
        sh1  <= PW'(r1);
        sh2  <= PW'(r2);
        dv   <= divisor;
        rem1 <= '0;
        rem2 <= '0;
      end else if (busy) begin
        rem1 <= step4(rem1, sh1[PW-1 -: 4], dv);
        rem2 <= step4(rem2, sh2[PW-1 -: 4], dv);
        sh1  <= sh1 << 4;
        sh2  <= sh2 << 4;
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/graph_cover_random_walk.sv
// Graph cover random walk engine: op 3 steps through the remainder unit and the dependent node and
// neighbour memory reads (a second neighbour read on a re-pick), then writes both node entries;
// op 1 reads both node entries and, when there is room, writes them back; op 4 reads one; ops 0 and 2 run
// a read-modify-write sweep of the node memory. Other ops go straight to the result state.
// Synchronous reset: a clearing sweep over the whole node memory follows, with
// req_stall high; configuration writes are taken throughout. One item in flight at a time.
module graph_cover_random_walk #(
  parameter int NODES      = 1024,
  parameter int MAX_DEGREE = 16,
  parameter int RAND_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [gcrw_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  gcrw_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output gcrw_pkg::rsp_t               rsp
);

  localparam int NW   = $clog2(NODES);
  localparam int DW   = $clog2(MAX_DEGREE + 1);
  localparam int SW   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int AW   = $clog2(NODES * MAX_DEGREE);
  localparam int EW   = ($clog2(NODES + 1) > gcrw_pkg::CFG_W) ? $clog2(NODES + 1)
                                                               : gcrw_pkg::CFG_W;
  localparam int RW   = (RAND_BITS < gcrw_pkg::RAND_W) ? RAND_BITS : gcrw_pkg::RAND_W;
  localparam int PC_W = NW + 1;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_ADD_A    = 4'd2;
  localparam logic [3:0] S_ADD_B    = 4'd3;
  localparam logic [3:0] S_ADD_WB   = 4'd4;
  localparam logic [3:0] S_STEP_DEG = 4'd5;
  localparam logic [3:0] S_STEP_MOD = 4'd6;
  localparam logic [3:0] S_STEP_N1  = 4'd7;
  localparam logic [3:0] S_STEP_N2  = 4'd8;
  localparam logic [3:0] S_STEP_V   = 4'd9;
  localparam logic [3:0] S_STEP_W   = 4'd10;
  localparam logic [3:0] S_QUERY    = 4'd11;
  localparam logic [3:0] S_RESULT   = 4'd12;

  localparam logic [1:0] PASS_ALL  = 2'd0;
  localparam logic [1:0] PASS_DEG  = 2'd1;
  localparam logic [1:0] PASS_WALK = 2'd2;

  typedef struct packed {
    logic [DW-1:0] degree;
    logic          parent_ok;
    logic [NW-1:0] parent;
    logic          visited;
    logic [gcrw_pkg::CNT_W-1:0] visits;
  } node_ent_t;

  // memories
  node_ent_t                     node_mem [NODES];
  logic [gcrw_pkg::NODE_W-1:0]   nbr_mem  [NODES * MAX_DEGREE];

  logic                          nm_we;
  logic [NW-1:0]                 nm_waddr;
  node_ent_t                     nm_wdata;
  logic [NW-1:0]                 nm_raddr;
  node_ent_t                     nm_rdata;
  logic                          nb_we;
  logic [AW-1:0]                 nb_waddr;
  logic [gcrw_pkg::NODE_W-1:0]   nb_wdata;
  logic [AW-1:0]                 nb_raddr;
  logic [gcrw_pkg::NODE_W-1:0]   nb_rdata;

  // control and walk state
  logic [3:0]                    state;
  logic [1:0]                    pass_mode;
  logic [PC_W-1:0]               pass_cnt;
  logic [gcrw_pkg::CFG_W-1:0]    node_count;
  logic [gcrw_pkg::NODE_W-1:0]   cur_node;
  logic [gcrw_pkg::COVER_W-1:0]  covered_total;
  logic [gcrw_pkg::CNT_W-1:0]    step_total;
  logic                          walk_active;

  // per-item working registers
  gcrw_pkg::req_t                item;
  node_ent_t                     ent_a;
  node_ent_t                     ent_b;
  node_ent_t                     ent_u;
  logic [gcrw_pkg::NODE_W-1:0]   dest;
  logic [gcrw_pkg::NODE_W-1:0]   res_node;
  logic [gcrw_pkg::CNT_W-1:0]    res_visits;
  logic [gcrw_pkg::STAT_W-1:0]   res_status;

  // helpers
  logic                          in_acc;
  logic                          rsp_free;
  logic [EW-1:0]                 eff;
  logic [EW-1:0]                 ncfg;
  logic                          req_a_bad;
  logic                          req_b_bad;
  logic                          done_now;
  logic                          done_next;
  logic [gcrw_pkg::COVER_W-1:0]  covered_next;
  logic [NW-1:0]                 a_idx;
  logic [NW-1:0]                 b_idx;
  logic [NW-1:0]                 cur_idx;
  logic [NW-1:0]                 dest_idx;
  logic [NW-1:0]                 pass_idx;
  logic [NW-1:0]                 pass_wr_idx;
  logic                          same_ab;
  logic                          add_full;
  logic                          repick;
  node_ent_t                     pass_ent;
  node_ent_t                     ent_a_inc;
  node_ent_t                     ent_b_base;
  node_ent_t                     ent_b_inc;
  node_ent_t                     ent_u_vis;
  node_ent_t                     ent_v;
  node_ent_t                     ent_v_new;

  logic                          mod_start;
  logic                          mod_done;
  logic [DW-1:0]                 rem1;
  logic [DW-1:0]                 rem2;

  function automatic logic [gcrw_pkg::CNT_W-1:0] sat_inc(input logic [gcrw_pkg::CNT_W-1:0] x);
    return (x == '1) ? x : x + gcrw_pkg::CNT_W'(1);
  endfunction

  function automatic logic [AW-1:0] nbr_addr(input logic [NW-1:0] nd, input logic [SW-1:0] sl);
    return AW'(nd) * AW'(MAX_DEGREE) + AW'(sl);
  endfunction

  gcrw_mod #(
    .RW (RW),
    .DW (DW)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .r1      (item.rand_first[RW-1:0]),
    .r2      (item.rand_second[RW-1:0]),
    .divisor (nm_rdata.degree),
    .done    (mod_done),
    .rem1    (rem1),
    .rem2    (rem2)
  );

  always_ff @(posedge clk) begin
    if (nm_we) begin
      node_mem[nm_waddr] <= nm_wdata;
    end
    nm_rdata <= node_mem[nm_raddr];
  end

  always_ff @(posedge clk) begin
    if (nb_we) begin
      nbr_mem[nb_waddr] <= nb_wdata;
    end
    nb_rdata <= nbr_mem[nb_raddr];
  end

  assign in_acc    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // node count clamped into [2, NODES]
  always_comb begin
    ncfg = EW'(node_count);
    if (ncfg < EW'(2)) begin
      eff = EW'(2);
    end else if (ncfg > EW'(NODES)) begin
      eff = EW'(NODES);
    end else begin
      eff = ncfg;
    end
  end

  assign req_a_bad = EW'(req.node_a) >= eff;
  assign req_b_bad = EW'(req.node_b) >= eff;
  assign done_now  = EW'(covered_total) >= eff - EW'(1);

  assign a_idx       = NW'(item.node_a);
  assign b_idx       = NW'(item.node_b);
  assign cur_idx     = NW'(cur_node);
  assign dest_idx    = NW'(dest);
  assign pass_idx    = pass_cnt[NW-1:0];
  assign pass_wr_idx = NW'(pass_cnt - PC_W'(1));
  assign same_ab     = (item.node_a == item.node_b);

  always_comb begin
    ent_a_inc        = ent_a;
    ent_a_inc.degree = ent_a.degree + DW'(1);
    ent_b_base       = same_ab ? ent_a_inc : ent_b;
    ent_b_inc        = ent_b_base;
    ent_b_inc.degree = ent_b_base.degree + DW'(1);

    // a self loop needs two free slots on its node
    if (same_ab) begin
      add_full = ({1'b0, ent_a.degree} + (DW + 1)'(2)) > (DW + 1)'(MAX_DEGREE);
    end else begin
      add_full = (ent_a.degree >= DW'(MAX_DEGREE)) || (nm_rdata.degree >= DW'(MAX_DEGREE));
    end

    ent_u_vis        = ent_u;
    ent_u_vis.visits = sat_inc(ent_u.visits);

    // forward the entry just written when the walk stays on its node
    ent_v               = (dest == cur_node) ? ent_u : nm_rdata;
    ent_v_new           = ent_v;
    ent_v_new.parent_ok = 1'b1;
    ent_v_new.parent    = cur_idx;
    ent_v_new.visited   = 1'b1;

    if (!ent_v.visited && covered_total != gcrw_pkg::COVER_MAX) begin
      covered_next = covered_total + gcrw_pkg::COVER_W'(1);
    end else begin
      covered_next = covered_total;
    end
    done_next = EW'(covered_next) >= eff - EW'(1);

    repick = (ent_u.degree != DW'(1)) && ent_u.parent_ok && (NW'(nb_rdata) == ent_u.parent);

    pass_ent = nm_rdata;
    case (pass_mode)
      PASS_DEG: begin
        pass_ent.degree = '0;
      end
      PASS_WALK: begin
        pass_ent.parent_ok = 1'b0;
        pass_ent.parent    = '0;
        pass_ent.visited   = (pass_wr_idx == a_idx);
        pass_ent.visits    = '0;
      end
      default: begin
        pass_ent = '0;
      end
    endcase
  end

  // memory port control
  always_comb begin
    nm_we     = 1'b0;
    nm_waddr  = pass_wr_idx;
    nm_wdata  = pass_ent;
    nm_raddr  = a_idx;
    nb_we     = 1'b0;
    nb_waddr  = nbr_addr(a_idx, SW'(ent_a.degree));
    nb_wdata  = item.node_b;
    nb_raddr  = nbr_addr(cur_idx, SW'(rem1));
    mod_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        nm_raddr = (req.op == gcrw_pkg::OP_STEP) ? cur_idx : NW'(req.node_a);
      end
      S_CLEAR: begin
        nm_raddr = (pass_cnt < PC_W'(NODES)) ? pass_idx : '0;
        nm_we    = (pass_cnt != '0);
      end
      S_ADD_A: begin
        nm_raddr = b_idx;
      end
      S_ADD_B: begin
        if (!add_full) begin
          nm_we    = 1'b1;
          nm_waddr = a_idx;
          nm_wdata = ent_a_inc;
          nb_we    = 1'b1;
        end
      end
      S_ADD_WB: begin
        nm_we    = 1'b1;
        nm_waddr = b_idx;
        nm_wdata = ent_b_inc;
        nb_we    = 1'b1;
        nb_waddr = nbr_addr(b_idx, SW'(ent_b_base.degree));
        nb_wdata = item.node_a;
      end
      S_STEP_DEG: begin
        mod_start = (nm_rdata.degree != '0);
      end
      S_STEP_N1: begin
        nb_raddr = nbr_addr(cur_idx, SW'(rem2));
      end
      S_STEP_V: begin
        nm_we    = 1'b1;
        nm_waddr = cur_idx;
        nm_wdata = ent_u_vis;
        nm_raddr = dest_idx;
      end
      S_STEP_W: begin
        nm_we    = 1'b1;
        nm_waddr = dest_idx;
        nm_wdata = ent_v_new;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      pass_mode     <= PASS_ALL;
      pass_cnt      <= '0;
      node_count    <= gcrw_pkg::NODE_COUNT_RST;
      cur_node      <= '0;
      covered_total <= '0;
      step_total    <= '0;
      walk_active   <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            item       <= req;
            res_node   <= req.node_a;
            res_visits <= '0;
            res_status <= gcrw_pkg::STAT_OK;
            unique case (req.op)
              gcrw_pkg::OP_CLEAR: begin
                pass_mode <= PASS_DEG;
                pass_cnt  <= '0;
                state     <= S_CLEAR;
              end
              gcrw_pkg::OP_ADD: begin
                if (req_a_bad || req_b_bad) begin
                  res_status <= gcrw_pkg::STAT_RANGE;
                  state      <= S_RESULT;
                end else begin
                  state <= S_ADD_A;
                end
              end
              gcrw_pkg::OP_START: begin
                if (req_a_bad) begin
                  res_status <= gcrw_pkg::STAT_RANGE;
                  state      <= S_RESULT;
                end else begin
                  pass_mode <= PASS_WALK;
                  pass_cnt  <= '0;
                  state     <= S_CLEAR;
                end
              end
              gcrw_pkg::OP_STEP: begin
                res_node <= cur_node;
                if (!walk_active) begin
                  res_status <= gcrw_pkg::STAT_NO_WALK;
                  state      <= S_RESULT;
                end else begin
                  state <= S_STEP_DEG;
                end
              end
              gcrw_pkg::OP_QUERY: begin
                if (req_a_bad) begin
                  res_status <= gcrw_pkg::STAT_RANGE;
                  state      <= S_RESULT;
                end else begin
                  state <= S_QUERY;
                end
              end
              default: begin
                state <= S_RESULT;
              end
            endcase
          end
        end
        S_CLEAR: begin
          if (pass_cnt == PC_W'(NODES)) begin
            if (pass_mode == PASS_WALK) begin
              cur_node      <= item.node_a;
              covered_total <= '0;
              step_total    <= '0;
              walk_active   <= 1'b1;
            end
            state <= (pass_mode == PASS_ALL) ? S_IDLE : S_RESULT;
          end else begin
            pass_cnt <= pass_cnt + PC_W'(1);
          end
        end
        S_ADD_A: begin
          ent_a <= nm_rdata;
          state <= S_ADD_B;
        end
        S_ADD_B: begin
          ent_b <= nm_rdata;
          if (add_full) begin
            res_status <= gcrw_pkg::STAT_FULL;
            state      <= S_RESULT;
          end else begin
            state <= S_ADD_WB;
          end
        end
        S_ADD_WB: begin
          state <= S_RESULT;
        end
        S_STEP_DEG: begin
          ent_u <= nm_rdata;
          if (nm_rdata.degree == '0) begin
            res_status <= gcrw_pkg::STAT_NO_NBR;
            state      <= S_RESULT;
          end else begin
            state <= S_STEP_MOD;
          end
        end
        S_STEP_MOD: begin
          if (mod_done) begin
            state <= S_STEP_N1;
          end
        end
        S_STEP_N1: begin
          // landed on the parent: re-pick once with the second value
          if (repick) begin
            state <= S_STEP_N2;
          end else begin
            dest  <= nb_rdata;
            state <= S_STEP_V;
          end
        end
        S_STEP_N2: begin
          dest  <= nb_rdata;
          state <= S_STEP_V;
        end
        S_STEP_V: begin
          ent_u      <= ent_u_vis;
          res_visits <= ent_u_vis.visits;
          state      <= S_STEP_W;
        end
        S_STEP_W: begin
          covered_total <= covered_next;
          cur_node      <= dest;
          step_total    <= sat_inc(step_total);
          if (done_next) begin
            walk_active <= 1'b0;
          end
          res_node <= dest;
          state    <= S_RESULT;
        end
        S_QUERY: begin
          res_visits <= nm_rdata.visits;
          state      <= S_RESULT;
        end
        S_RESULT: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            rsp       <= '{node:        res_node,
                           visit_count: res_visits,
                           covered:     covered_total,
                           steps:       step_total,
                           done_res:    done_now,
                           status:      res_status};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the remainder unit only finishes while the step sequencer waits for it
  a_mod_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_STEP_MOD))
    else $error("remainder done outside its wait state");

  // a new word appears only from the result state
  a_rsp_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_RESULT))
    else $error("response word raised outside result state");

  // the step count moves only on a step or at the end of a walk start sweep
  a_steps_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(step_total)) |->
      ($past(state) == S_STEP_W || $past(state) == S_CLEAR))
    else $error("step count changed outside a step");

  // each step covers at most one new node
  a_cover_le_steps: assert property (@(posedge clk) disable iff (rst)
    gcrw_pkg::CNT_W'(covered_total) <= step_total)
    else $error("covered count ahead of step count");

endmodule
